>>> rtl/core/assert_macros.svh
// Assertion helpers for the block decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define BMC_ASSERT_IMP(label, clk, rst_n, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);
// Next-cycle implication checked outside reset.
`define BMC_ASSERT_NXT(label, clk, rst_n, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
`endif

>>> rtl/core/bmc_pkg.sv
// ----------------------------------------------------------------------------
// bmc_pkg
// Shared types and constants of the block motion-compensated decoder.
// ----------------------------------------------------------------------------
package bmc_pkg;
  localparam int MaxWidth  = 512;
  localparam int MaxHeight = 512;
  localparam int BlockSize = 4;
  localparam int XW = $clog2(MaxWidth);
  localparam int YW = $clog2(MaxHeight);
  // Memory word holds four pixels; one slot has MaxHeight * MaxWidth/4 words.
  localparam int GW = $clog2(MaxWidth / BlockSize);
  localparam int AW = 2 + YW + GW;

  localparam logic [2:0] OP_MV_LAST  = 3'd0;
  localparam logic [2:0] OP_MV_OLDER = 3'd1;
  localparam logic [2:0] OP_LITERAL  = 3'd2;
  localparam logic [2:0] OP_RASTER   = 3'd3;
  localparam logic [2:0] OP_EOF      = 3'd4;

  localparam logic [0:0] REG_WIDTH  = 1'b0;
  localparam logic [0:0] REG_HEIGHT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_RD, ST_WAIT, ST_WR, ST_OUT
  } bmc_state_t;

  // Memory request from the sequencer.
  typedef struct packed {
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_data;
    logic [3:0]    wr_mask;
  } bmc_mem_req_t;
endpackage

>>> rtl/core/bmc_ram.sv
// ----------------------------------------------------------------------------
// bmc_ram
// Frame store: 32-bit words, byte write enables, registered read.
// ----------------------------------------------------------------------------
module bmc_ram
  import bmc_pkg::*;
(
  input  logic         clk,
  input  bmc_mem_req_t req,
  output logic [31:0]  rd_data
);
  logic [31:0] mem [3*MaxHeight*(MaxWidth/BlockSize)];
  logic [31:0] rd_data_r;

  // Byte-masked write port.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      for (int b = 0; b < 4; b++) begin
        if (req.wr_mask[b]) mem[req.wr_addr][8*b +: 8] <= req.wr_data[8*b +: 8];
      end
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (req.rd_en) rd_data_r <= mem[req.rd_addr];
  end
  assign rd_data = rd_data_r;
endmodule

>>> rtl/core/bmc_seq.sv
// ----------------------------------------------------------------------------
// bmc_seq
// Sequencer: walks the rows of one request, reads the reference words,
// assembles the displaced row and writes it to the current frame.
// ----------------------------------------------------------------------------
module bmc_seq
  import bmc_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic [2:0]   in_op,
  input  logic [6:0]   in_block_x,
  input  logic [8:0]   in_block_y,
  input  logic [7:0]   in_vector,
  input  logic [31:0]  in_row0,
  input  logic [31:0]  in_row1,
  input  logic [31:0]  in_row2,
  input  logic [31:0]  in_row3,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [0:0]   cfg_index,
  input  logic [9:0]   cfg_data,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [6:0]   out_x,
  output logic [8:0]   out_y,
  output logic [31:0]  out_pixels,
  output logic         out_written,
  output logic         out_last,
  output bmc_mem_req_t mem_req,
  input  logic [31:0]  mem_rd_data
);
  bmc_state_t st_r, st_nxt;
  logic [9:0]  width_r, height_r;
  logic [1:0]  cur_r, prev_r, old_r;
  logic        prev_ok_r, old_ok_r;
  // Captured request.
  logic [2:0]  op_r;
  logic [6:0]  bx_r;
  logic [8:0]  by_r;
  logic [7:0]  vec_r;
  logic [31:0] rows_r [4];
  logic        store_r;
  logic [1:0]  row_r;
  logic        half_r;        // which of two source words is being read
  logic [31:0] w0_r;          // first source word of this row
  logic [31:0] res_r;
  logic        ov_r, olast_r, owr_r;
  logic [8:0]  oy_r;

  // Effective dimensions, saturated to the store size.
  logic [XW:0] w_eff;
  logic [YW:0] h_eff;
  assign w_eff = (width_r  > 10'(MaxWidth))  ? (XW+1)'(MaxWidth)  : (XW+1)'(width_r);
  assign h_eff = (height_r > 10'(MaxHeight)) ? (YW+1)'(MaxHeight) : (YW+1)'(height_r);

  // Geometry of the current row.
  logic [10:0] x0, y_row;
  logic signed [12:0] sx0, sy;
  logic [1:0]  src_slot;
  logic        motion;
  logic [10:0] sx_word0;
  assign motion   = (op_r == OP_MV_LAST) || (op_r == OP_MV_OLDER);
  assign x0       = {2'b0, bx_r, 2'b0};
  assign y_row    = (op_r == OP_RASTER) ? {2'b0, by_r} : {by_r, row_r};
  assign sx0      = $signed({2'b0, x0}) + $signed({9'b0, vec_r[3:0]}) - 13'sd7;
  assign sy       = $signed({2'b0, y_row}) + $signed({9'b0, vec_r[7:4]}) - 13'sd7;
  assign src_slot = (op_r == OP_MV_LAST) ? prev_r : old_r;
  assign sx_word0 = sx0[12:2] + {10'b0, half_r};

  logic sy_in;
  assign sy_in = (sy >= 0) && (sy < $signed({2'b0, h_eff}));

  // Assemble four displaced pixels from two adjacent words.
  logic [63:0] pair;
  logic [31:0] mv_row;
  always_comb begin
    pair = {mem_rd_data, w0_r} >> (8 * sx0[1:0]);
    for (int c = 0; c < 4; c++) begin
      logic signed [12:0] px;
      px = sx0 + 13'(c);
      mv_row[8*c +: 8] = (sy_in && px >= 0 && px < $signed({2'b0, w_eff})) ?
                         pair[8*c +: 8] : 8'h00;
    end
  end

  // Raster clip mask.
  logic [3:0]  ras_mask;
  logic [31:0] ras_pix;
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      ras_mask[c] = (x0 + 11'(c)) < {1'b0, w_eff};
      ras_pix[8*c +: 8] = ras_mask[c] ? rows_r[0][8*c +: 8] : 8'h00;
    end
  end

  logic [31:0] row_data;
  assign row_data = motion ? mv_row : (op_r == OP_RASTER ? ras_pix : rows_r[row_r]);

  // A configuration write takes the idle cycle and holds off a request in it.
  logic accept, out_take;
  assign in_stall  = (st_r != ST_IDLE) || cfg_valid;
  assign accept    = in_valid && !in_stall;
  assign out_take  = ov_r && !out_stall;
  assign cfg_ready = (st_r == ST_IDLE);

  // Next state and memory requests.
  always_comb begin
    st_nxt = st_r;
    mem_req = '0;
    mem_req.rd_addr = {src_slot, sy[YW-1:0], sx_word0[GW-1:0]};
    mem_req.wr_addr = {cur_r, y_row[YW-1:0], bx_r[GW-1:0]};
    mem_req.wr_data = row_data;
    mem_req.wr_mask = (op_r == OP_RASTER) ? ras_mask : 4'hF;
    case (st_r)
      ST_IDLE: if (accept && in_op <= OP_RASTER) st_nxt = ST_RD;
      ST_RD: begin
        if (store_r && motion) begin
          mem_req.rd_en = 1'b1;
          st_nxt = half_r ? ST_WAIT : ST_RD;
        end else begin
          st_nxt = ST_WR;
        end
      end
      ST_WAIT: st_nxt = ST_WR;
      ST_WR: begin
        mem_req.wr_en = store_r;
        st_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_take) st_nxt = (olast_r) ? ST_IDLE : ST_RD;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; width_r <= 10'd320; height_r <= 10'd240;
      cur_r <= 2'd0; prev_r <= 2'd1; old_r <= 2'd2;
      prev_ok_r <= 1'b0; old_ok_r <= 1'b0;
      ov_r <= 1'b0; half_r <= 1'b0; row_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_WIDTH) width_r <= cfg_data;
        else height_r <= cfg_data;
        prev_ok_r <= 1'b0; old_ok_r <= 1'b0;
      end
      if (accept && in_op == OP_EOF) begin
        cur_r <= old_r; old_r <= prev_r; prev_r <= cur_r;
        old_ok_r <= prev_ok_r; prev_ok_r <= 1'b1;
      end
      if (accept) begin
        row_r <= '0; half_r <= 1'b0;
      end
      if (st_r == ST_RD && mem_req.rd_en) half_r <= ~half_r;
      if (st_r == ST_WR) ov_r <= 1'b1;
      if (out_take) begin
        ov_r <= 1'b0;
        row_r <= row_r + 2'd1;
      end
    end
  end

  // Request capture and result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r <= in_op; bx_r <= in_block_x; by_r <= in_block_y; vec_r <= in_vector;
      rows_r[0] <= in_row0; rows_r[1] <= in_row1;
      rows_r[2] <= in_row2; rows_r[3] <= in_row3;
    end
    if (st_r == ST_WAIT) w0_r <= w0_r;
    if (st_r == ST_RD && half_r) w0_r <= mem_rd_data;
    if (st_r == ST_WR) begin
      res_r   <= store_r ? row_data : 32'h0;
      owr_r   <= store_r;
      oy_r    <= y_row[8:0];
      olast_r <= (op_r == OP_RASTER) || (row_r == 2'd3);
    end
  end

  // Store decision, fixed for the whole request and taken when it is accepted.
  logic ref_ok, fits, in_store;
  assign ref_ok = (in_op == OP_MV_LAST) ? prev_ok_r :
                  (in_op == OP_MV_OLDER) ? old_ok_r : 1'b1;
  assign fits = ({2'b0, in_block_x, 2'b0} + 11'd4 <= {1'b0, w_eff}) &&
                ({1'b0, in_block_y, 2'b0} + 12'd4 <= {2'b0, h_eff});
  assign in_store = (in_op == OP_RASTER) ? ({1'b0, in_block_y} < h_eff) : (ref_ok && fits);
  always_ff @(posedge clk) begin
    if (accept) store_r <= in_store;
  end

  assign out_valid   = ov_r;
  assign out_x       = bx_r;
  assign out_y       = oy_r;
  assign out_pixels  = res_r;
  assign out_written = owr_r;
  assign out_last    = olast_r;
endmodule

>>> rtl/core/block_motion_comp_decoder_top.sv
// ----------------------------------------------------------------------------
// block_motion_comp_decoder_top
// Motion-compensated / literal / raster block decoder over three frame stores.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake      Payload
// in       input      valid / stall  op, block_x, block_y, vector, row0..row3
// out      output     valid / stall  out_x, out_y, pixels, written, last
// cfg      input      valid / ready  index, data (frame_width, frame_height)
// A stored motion row steps through two word reads on the one read port,
// a wait, the write and the result; any other row goes from the read state
// straight to the write and the result. Motion, literal and unstored blocks
// have four rows, a raster write one; end of frame and unused ops start none.
// Reset is synchronous, active low; the frame store is not cleared.
// An output stall holds the sequencer in the result state until the row is taken.
`include "assert_macros.svh"
module block_motion_comp_decoder_top
  import bmc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_op,
  input  logic [6:0]  in_block_x,
  input  logic [8:0]  in_block_y,
  input  logic [7:0]  in_vector,
  input  logic [31:0] in_row0,
  input  logic [31:0] in_row1,
  input  logic [31:0] in_row2,
  input  logic [31:0] in_row3,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [9:0]  cfg_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [6:0]  out_x,
  output logic [8:0]  out_y,
  output logic [31:0] out_pixels,
  output logic        out_written,
  output logic        out_last
);
  bmc_mem_req_t mem_req;
  logic [31:0]  mem_rd_data;

  bmc_seq u_seq (.*);
  bmc_ram u_ram (.clk(clk), .req(mem_req), .rd_data(mem_rd_data));

  // A result that was not written carries no pixels.
  `BMC_ASSERT_IMP(a_unwritten_zero, clk, rst_n, out_valid && !out_written,
    out_pixels == 32'h0, "unwritten result carries pixels")
  // No new request while a result is pending.
  `BMC_ASSERT_IMP(a_busy_stall, clk, rst_n, out_valid, in_stall,
    "request accepted while result pending")
  // Configuration is only taken while idle.
  `BMC_ASSERT_IMP(a_cfg_idle, clk, rst_n, cfg_ready, !out_valid,
    "configuration taken while busy")
endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Block decoder testbench
// Drives motion, literal, raster and end-of-frame requests into the decoder
// under random sender gaps and receiver stalls, over several frame sizes, and
// checks every result row against a predictor that keeps its own frame stores.
// ----------------------------------------------------------------------------
module testbench;
  import bmc_pkg::*;

  localparam int SlotWords = MaxWidth * MaxHeight;
  localparam int DrainCycles = 60;

  typedef struct packed {
    logic [2:0]       op;
    logic [6:0]       bx;
    logic [8:0]       by;
    logic [7:0]       vec;
    logic [3:0][31:0] rows;
    logic             typed_zero;
  } blk_req_t;

  typedef struct packed {
    logic [6:0]  x;
    logic [8:0]  y;
    logic [31:0] pixels;
    logic        written;
    logic        last;
  } row_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_op = '0;
  logic [6:0]  in_block_x = '0;
  logic [8:0]  in_block_y = '0;
  logic [7:0]  in_vector = '0;
  logic [31:0] in_row0 = '0, in_row1 = '0, in_row2 = '0, in_row3 = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_index = '0;
  logic [9:0]  cfg_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [6:0]  out_x;
  logic [8:0]  out_y;
  logic [31:0] out_pixels;
  logic        out_written;
  logic        out_last;

  block_motion_comp_decoder_top uut (.*);

  always #6 clk = ~clk;

  // Predictor state: the three frame stores, which pixels have been written,
  // the slot rotation and the frame size registers.
  logic [7:0] pix_mem [3*SlotWords];
  bit         pix_set [3*SlotWords];
  int         cur_slot = 0, prev_slot = 1, old_slot = 2;
  bit         prev_ok = 1'b0, old_ok = 1'b0;
  int         reg_w = 320, reg_h = 240;

  row_res_t   rows_due_q [$];
  int         err_count = 0;
  int         burst_left = 0;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  function automatic int pix_at(input int slot, input int x, input int y);
    return slot * SlotWords + (y % MaxHeight) * MaxWidth + (x % MaxWidth);
  endfunction

  function automatic int eff_w();
    return reg_w > MaxWidth ? MaxWidth : reg_w;
  endfunction

  function automatic int eff_h();
    return reg_h > MaxHeight ? MaxHeight : reg_h;
  endfunction

  // True when a motion request would only read pixels that were written.
  function automatic bit motion_reads_known(input blk_req_t rq);
    int w, h, x0, y0, src, sx, sy;
    bit ok;
    w = eff_w();
    h = eff_h();
    x0 = rq.bx * BlockSize;
    y0 = rq.by * BlockSize;
    ok = 1'b1;
    if (rq.op != OP_MV_LAST && rq.op != OP_MV_OLDER) return 1'b1;
    if (rq.op == OP_MV_LAST ? !prev_ok : !old_ok) return 1'b1;
    if (x0 + BlockSize > w || y0 + BlockSize > h) return 1'b1;
    src = rq.op == OP_MV_LAST ? prev_slot : old_slot;
    for (int r = 0; r < BlockSize; r++) begin
      for (int c = 0; c < BlockSize; c++) begin
        sx = x0 + c + int'(rq.vec[3:0]) - 7;
        sy = y0 + r + int'(rq.vec[7:4]) - 7;
        if (sx >= 0 && sx < w && sy >= 0 && sy < h && !pix_set[pix_at(src, sx, sy)])
          ok = 1'b0;
      end
    end
    return ok;
  endfunction

  // Apply one accepted request to the frame stores and queue its result rows.
  function automatic void decode_request(input blk_req_t rq);
    int w, h, x0, y0, src, sx, sy, x, y, tmp;
    bit motion, ref_ok, store;
    logic [7:0] v;
    logic [31:0] px;
    row_res_t res;
    w = eff_w();
    h = eff_h();
    x0 = rq.bx * BlockSize;
    y0 = rq.by * BlockSize;
    case (rq.op)
      OP_MV_LAST, OP_MV_OLDER, OP_LITERAL: begin
        motion = rq.op != OP_LITERAL;
        ref_ok = rq.op == OP_MV_LAST ? prev_ok : (rq.op == OP_MV_OLDER ? old_ok : 1'b1);
        src = rq.op == OP_MV_LAST ? prev_slot : old_slot;
        store = ref_ok && (x0 + BlockSize <= w) && (y0 + BlockSize <= h);
        for (int r = 0; r < BlockSize; r++) begin
          y = y0 + r;
          px = '0;
          if (store) begin
            for (int c = 0; c < BlockSize; c++) begin
              x = x0 + c;
              if (motion) begin
                sx = x + int'(rq.vec[3:0]) - 7;
                sy = y + int'(rq.vec[7:4]) - 7;
                v = (sx >= 0 && sx < w && sy >= 0 && sy < h) ? pix_mem[pix_at(src, sx, sy)] : 8'd0;
              end else begin
                v = rq.rows[r][8*c +: 8];
              end
              pix_mem[pix_at(cur_slot, x, y)] = v;
              pix_set[pix_at(cur_slot, x, y)] = 1'b1;
              px[8*c +: 8] = v;
            end
          end
          res = '{x: rq.bx, y: y[8:0], pixels: px, written: store, last: r == BlockSize - 1};
          if (rq.typed_zero) begin
            res.pixels = '0;
            res.written = 1'b0;
          end
          rows_due_q.push_back(res);
        end
      end
      OP_RASTER: begin
        store = rq.by < h;
        px = '0;
        if (store) begin
          for (int c = 0; c < BlockSize; c++) begin
            x = x0 + c;
            if (x < w) begin
              v = rq.rows[0][8*c +: 8];
              pix_mem[pix_at(cur_slot, x, rq.by)] = v;
              pix_set[pix_at(cur_slot, x, rq.by)] = 1'b1;
              px[8*c +: 8] = v;
            end
          end
        end
        res = '{x: rq.bx, y: rq.by, pixels: px, written: store, last: 1'b1};
        if (rq.typed_zero) begin
          res.pixels = '0;
          res.written = 1'b0;
        end
        rows_due_q.push_back(res);
      end
      OP_EOF: begin
        tmp = old_slot;
        old_slot = prev_slot;
        prev_slot = cur_slot;
        cur_slot = tmp;
        old_ok = prev_ok;
        prev_ok = 1'b1;
      end
      default: ;
    endcase
  endfunction

  // Send one request in bursts; the predictor sees it once it is accepted.
  task automatic send_request(input blk_req_t rq);
    int gap;
    if (!motion_reads_known(rq)) rq.op = OP_LITERAL;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_valid   <= 1'b1;
    in_op      <= rq.op;
    in_block_x <= rq.bx;
    in_block_y <= rq.by;
    in_vector  <= rq.vec;
    in_row0    <= rq.rows[0];
    in_row1    <= rq.rows[1];
    in_row2    <= rq.rows[2];
    in_row3    <= rq.rows[3];
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    decode_request(rq);
    burst_left--;
  endtask

  // Wait until every result has come and the block has gone quiet.
  task automatic wait_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (rows_due_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [9:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_WIDTH) reg_w = int'(val);
    else reg_h = int'(val);
    prev_ok = 1'b0;
    old_ok = 1'b0;
    @(posedge clk);
  endtask

  function automatic blk_req_t random_request();
    blk_req_t rq;
    int sel, w, h;
    w = eff_w();
    h = eff_h();
    sel = $urandom_range(0, 99);
    rq.op = sel < 30 ? OP_MV_LAST : sel < 48 ? OP_MV_OLDER : sel < 63 ? OP_LITERAL :
            sel < 80 ? OP_RASTER : sel < 92 ? OP_EOF : 3'($urandom_range(5, 7));
    rq.bx = ($urandom_range(0, 4) == 0) ? 7'($urandom) : 7'($urandom_range(0, (w + 3) / 4));
    if (rq.op == OP_RASTER)
      rq.by = ($urandom_range(0, 4) == 0) ? 9'($urandom) : 9'($urandom_range(0, h));
    else
      rq.by = ($urandom_range(0, 4) == 0) ? 9'($urandom) : 9'($urandom_range(0, (h + 3) / 4));
    if ($urandom_range(0, 3) == 0)
      rq.vec = 8'($urandom);
    else
      rq.vec = {4'($urandom_range(5, 9)), 4'($urandom_range(5, 9))};
    for (int r = 0; r < 4; r++) rq.rows[r] = $urandom;
    rq.typed_zero = 1'b0;
    return rq;
  endfunction

  // Receiver stall pattern, in one of four randomly drawn modes.
  int stall_cnt = 0;
  int stall_mode = 0;
  always @(posedge clk) begin
    stall_cnt <= stall_cnt + 1;
    if (stall_cnt % 64 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 1) == 0);
      2: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= (stall_cnt % 16) < 9;
    endcase
  end

  // Compare each accepted result row with the oldest expected row.
  always @(negedge clk) begin
    row_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (rows_due_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result x=%0d y=%0d", out_x, out_y));
      end else begin
        want = rows_due_q.pop_front();
        if (out_x !== want.x)
          report_mismatch($sformatf("out_x %0d, want %0d", out_x, want.x));
        if (out_y !== want.y)
          report_mismatch($sformatf("out_y %0d, want %0d", out_y, want.y));
        if (out_pixels !== want.pixels)
          report_mismatch($sformatf("pixels %h, want %h (y=%0d)", out_pixels, want.pixels, want.y));
        if (out_written !== want.written)
          report_mismatch($sformatf("written %b, want %b", out_written, want.written));
        if (out_last !== want.last)
          report_mismatch($sformatf("last %b, want %b", out_last, want.last));
      end
    end
  end

  // Directed requests at the reset frame size of 320 x 240.
  localparam int DirCount = 18;
  localparam logic [127:0] AllOnes = {128{1'b1}};
  blk_req_t dir_tab [DirCount] = '{
    '{OP_MV_LAST,  7'd0,   9'd0,   8'h77, 128'd0, 1'b1},
    '{OP_MV_OLDER, 7'd0,   9'd0,   8'h77, 128'd0, 1'b1},
    '{OP_LITERAL,  7'd0,   9'd0,   8'h00, {32'h0, 32'hFFFFFFFF, 32'h0, 32'hFFFFFFFF}, 1'b0},
    '{OP_LITERAL,  7'd127, 9'd511, 8'hFF, AllOnes, 1'b1},
    '{OP_RASTER,   7'd5,   9'd511, 8'h00, AllOnes, 1'b1},
    '{OP_RASTER,   7'd79,  9'd239, 8'h00, {96'd0, 32'hA5C3_0FF0}, 1'b0},
    '{OP_RASTER,   7'd80,  9'd10,  8'h00, AllOnes, 1'b0},
    '{3'd5,        7'd1,   9'd1,   8'h11, AllOnes, 1'b0},
    '{3'd6,        7'd2,   9'd2,   8'h22, AllOnes, 1'b0},
    '{3'd7,        7'd3,   9'd3,   8'h33, AllOnes, 1'b0},
    '{OP_LITERAL,  7'd79,  9'd59,  8'h00, {32'h1234_5678, 32'h9ABC_DEF0, 32'h0F1E_2D3C,
                                            32'h4B5A_6978}, 1'b0},
    '{OP_EOF,      7'd0,   9'd0,   8'h00, 128'd0, 1'b0},
    '{OP_MV_LAST,  7'd0,   9'd0,   8'h77, 128'd0, 1'b0},
    '{OP_MV_LAST,  7'd0,   9'd0,   8'h00, 128'd0, 1'b0},
    '{OP_MV_LAST,  7'd79,  9'd59,  8'hFF, 128'd0, 1'b0},
    '{OP_MV_OLDER, 7'd0,   9'd0,   8'h77, 128'd0, 1'b1},
    '{OP_EOF,      7'd0,   9'd0,   8'h00, 128'd0, 1'b0},
    '{OP_MV_OLDER, 7'd0,   9'd0,   8'h77, 128'd0, 1'b0}
  };

  // Frame sizes of the random phases; over-range values saturate.
  localparam int PhaseCount = 7;
  int phase_w [PhaseCount] = '{1, 1023, 8, 6, 13, 4, 512};
  int phase_h [PhaseCount] = '{1, 1023, 8, 5, 9, 4, 3};

  initial begin
    blk_req_t rq;
    int done_items, guard;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) send_request(dir_tab[i]);
    wait_idle();

    for (int p = 0; p < PhaseCount; p++) begin
      write_reg(REG_WIDTH, 10'(phase_w[p]));
      write_reg(REG_HEIGHT, 10'(phase_h[p]));
      done_items = 0;
      while (done_items < 16) begin
        // Small frames get a full raster fill at the start of the phase.
        if (eff_w() * eff_h() <= 200 && done_items == 0) begin
          for (int y = 0; y < eff_h(); y++) begin
            for (int g = 0; g < (eff_w() + 3) / 4; g++) begin
              rq = '{OP_RASTER, 7'(g), 9'(y), 8'($urandom), {96'd0, 32'($urandom)}, 1'b0};
              send_request(rq);
            end
          end
        end
        rq = random_request();
        send_request(rq);
        if (rq.op <= OP_EOF) done_items++;
      end
      wait_idle();
    end

    guard = 0;
    while (rows_due_q.size() != 0 && guard < 10000) begin
      @(posedge clk);
      guard++;
    end
    repeat (DrainCycles) @(posedge clk);
    if (err_count == 0 && rows_due_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Run limit, far above the slowest correct run.
  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/bmc_pkg.sv
rtl/core/bmc_ram.sv
rtl/core/bmc_seq.sv
rtl/core/block_motion_comp_decoder_top.sv
sim/testbench.sv
